// ===== design/ira_pkg.sv =====
// iova range allocator package: request codes, sequencer states and the
// result record passed from the sequencer to the top level
// no dependencies
package ira_pkg;

    localparam int FIELD_W = 48;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_REL   = 2'd2;

    typedef enum logic {
        TBL_POOL,
        TBL_USED
    } tbl_t;

    typedef enum logic {
        R_POST,
        R_DONE
    } ret_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_AR_RD,
        S_AR_CHK,
        S_AR_WR,
        S_PO_PREP,
        S_PO_CHK,
        S_PO_WR,
        S_MG_RD,
        S_MG_CHK,
        S_MG_FIN,
        S_MG_WR,
        S_SH_RD,
        S_SH_WR,
        S_INS_RD,
        S_INS_CHK,
        S_INS_WR,
        S_AL_RD,
        S_AL_DIF,
        S_AL_CAND,
        S_AL_TEST,
        S_AL_VRD,
        S_AL_VCHK,
        S_RL_RD,
        S_RL_CHK,
        S_RL_FIX
    } state_t;

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic [FIELD_W-1:0] addr;
    } res_t;

endpackage

// ===== design/ira_mem.sv =====
// region table storage: one synchronous memory, one write and one read port,
// read data registered; no dependencies
module ira_mem #(
    parameter int AW = 7,
    parameter int DW = 96
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ira_seq.sv =====
// request sequencer: walks, merges, shifts and searches the pool and used
// tables held in ira_mem; uses ira_pkg for codes, states and the result record
module ira_seq #(
    parameter int MAX_REGIONS = 64,
    parameter int ADDR_BITS   = 48,
    localparam int IW = $clog2(MAX_REGIONS),
    localparam int CW = $clog2(MAX_REGIONS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [1:0]                 func,
    input  logic [ira_pkg::FIELD_W-1:0] base,
    input  logic [ira_pkg::FIELD_W-1:0] size,
    input  logic [5:0]                 align_shift,
    output logic                       busy,
    output ira_pkg::res_t              res,
    output logic                       mem_we,
    output logic [IW:0]                mem_waddr,
    output logic [2*ADDR_BITS-1:0]     mem_wdata,
    output logic [IW:0]                mem_raddr,
    input  logic [2*ADDR_BITS-1:0]     mem_rdata
);

    localparam int A = ADDR_BITS;

    function automatic logic [A-1:0] span_of(input logic [A-1:0] b, input logic [A-1:0] last);
        logic [A-1:0] d;
        d = last - b;
        return (d == '1) ? d : d + A'(1);
    endfunction

    ira_pkg::state_t state_reg, state_next;
    ira_pkg::ret_t   ret_reg, ret_next;
    ira_pkg::tbl_t   tsel_reg, tsel_next;
    logic [1:0]      func_reg, func_next;
    logic [5:0]      sh_reg, sh_next;
    logic [A-1:0]    nb_reg, nb_next, nl_reg, nl_next, nlast_reg, nlast_next;
    logic [A-1:0]    cand_reg, cand_next, endl_reg, endl_next, firstb_reg, firstb_next;
    logic [A-1:0]    eb_reg, eb_next, el_reg, el_next, elast_reg, elast_next;
    logic [A-1:0]    spb_reg, spb_next, spy_reg, spy_next;
    logic [A-1:0]    pb_reg, pb_next, diff_reg, diff_next;
    logic [A-1:0]    rb_reg, rb_next, rl_reg, rl_next, rlen_reg, rlen_next;
    logic [CW-1:0]   i_reg, i_next, k_reg, k_next, hits_reg, hits_next;
    logic [CW-1:0]   dst_reg, dst_next, gap_reg, gap_next, ai_reg, ai_next;
    logic [CW-1:0]   pool_cnt_reg, pool_cnt_next, used_cnt_reg, used_cnt_next;

    logic [A-1:0]    am;
    logic [A-1:0]    rd_b, rd_l, rd_last, nlast_w, sp_len;
    logic [CW-1:0]   cnt, i_inc, i_dec, ai_dec;
    logic [CW:0]     sh_sum;
    logic            fin, fin_ok;
    logic            c_front, c_back, c_ovl;

    // alignment mask: keep bits at or above the shift
    always_comb
    begin
        for (int p = 0; p < A; p++)
        begin
            am[p] = (p >= int'(sh_reg));
        end
    end

    assign rd_b    = mem_rdata[2*A-1:A];
    assign rd_l    = mem_rdata[A-1:0];
    assign rd_last = rd_b + rd_l - A'(1);
    assign nlast_w = nb_reg + nl_reg - A'(1);
    assign sp_len  = span_of(spb_reg, spy_reg);
    assign cnt     = (tsel_reg == ira_pkg::TBL_USED) ? used_cnt_reg : pool_cnt_reg;
    assign i_inc   = i_reg + CW'(1);
    assign i_dec   = i_reg - CW'(1);
    assign ai_dec  = ai_reg - CW'(1);
    assign sh_sum  = {1'b0, dst_reg} + {1'b0, gap_reg};
    assign busy    = (state_reg != ira_pkg::S_IDLE);

    // touch tests of the new range against the entry just read
    assign c_front = (({1'b0, nlast_reg} + (A+1)'(1)) == {1'b0, rd_b});
    assign c_back  = (({1'b0, rd_last} + (A+1)'(1)) == {1'b0, nb_reg});
    assign c_ovl   = (nb_reg <= rd_last) && (rd_b <= nlast_reg);

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        tsel_next     = tsel_reg;
        func_next     = func_reg;
        sh_next       = sh_reg;
        nb_next       = nb_reg;
        nl_next       = nl_reg;
        nlast_next    = nlast_reg;
        cand_next     = cand_reg;
        endl_next     = endl_reg;
        firstb_next   = firstb_reg;
        eb_next       = eb_reg;
        el_next       = el_reg;
        elast_next    = elast_reg;
        spb_next      = spb_reg;
        spy_next      = spy_reg;
        pb_next       = pb_reg;
        diff_next     = diff_reg;
        rb_next       = rb_reg;
        rl_next       = rl_reg;
        rlen_next     = rlen_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        hits_next     = hits_reg;
        dst_next      = dst_reg;
        gap_next      = gap_reg;
        ai_next       = ai_reg;
        pool_cnt_next = pool_cnt_reg;
        used_cnt_next = used_cnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = {tsel_reg, i_reg[IW-1:0]};
        mem_wdata     = {spb_reg, sp_len};
        mem_raddr     = {tsel_reg, i_reg[IW-1:0]};
        fin           = 1'b0;
        fin_ok        = 1'b0;

        unique case (state_reg)
            ira_pkg::S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    nb_next    = A'(base);
                    nl_next    = A'(size);
                    sh_next    = align_shift;
                    state_next = ira_pkg::S_PREP;
                end
            end
            ira_pkg::S_PREP:
            begin
                priority case (func_reg)
                    ira_pkg::FUNC_ADD:
                    begin
                        if (nl_reg == '0 || nlast_w < nb_reg)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            tsel_next  = ira_pkg::TBL_POOL;
                            nlast_next = nlast_w;
                            i_next     = '0;
                            state_next = ira_pkg::S_AR_RD;
                        end
                    end
                    ira_pkg::FUNC_ALLOC:
                    begin
                        if (nl_reg == '0)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            ai_next    = pool_cnt_reg;
                            state_next = ira_pkg::S_AL_RD;
                        end
                    end
                    ira_pkg::FUNC_REL:
                    begin
                        if (nl_reg == '0 || nlast_w < nb_reg)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            tsel_next  = ira_pkg::TBL_USED;
                            nlast_next = nlast_w;
                            i_next     = '0;
                            state_next = ira_pkg::S_RL_RD;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            // add a range to the selected table
            ira_pkg::S_AR_RD:
            begin
                if (i_reg == cnt)
                begin
                    if (cnt >= CW'(MAX_REGIONS))
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        state_next = ira_pkg::S_INS_RD;
                    end
                end
                else
                begin
                    state_next = ira_pkg::S_AR_CHK;
                end
            end
            ira_pkg::S_AR_CHK:
            begin
                priority if (c_front)
                begin
                    spb_next   = nb_reg;
                    spy_next   = rd_last;
                    state_next = ira_pkg::S_AR_WR;
                end
                else if (c_back)
                begin
                    spb_next   = rd_b;
                    spy_next   = nlast_reg;
                    state_next = ira_pkg::S_AR_WR;
                end
                else if (c_ovl)
                begin
                    k_next     = i_reg;
                    hits_next  = '0;
                    ret_next   = ira_pkg::R_POST;
                    state_next = ira_pkg::S_MG_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ira_pkg::S_AR_RD;
                end
            end
            ira_pkg::S_AR_WR:
            begin
                mem_we     = 1'b1;
                eb_next    = spb_reg;
                el_next    = sp_len;
                state_next = ira_pkg::S_PO_PREP;
            end
            // after a join, look at the upper neighbour
            ira_pkg::S_PO_PREP:
            begin
                if (i_inc >= cnt)
                begin
                    fin    = 1'b1;
                    fin_ok = 1'b1;
                end
                else
                begin
                    mem_raddr  = {tsel_reg, i_inc[IW-1:0]};
                    elast_next = eb_reg + el_reg - A'(1);
                    state_next = ira_pkg::S_PO_CHK;
                end
            end
            ira_pkg::S_PO_CHK:
            begin
                priority if (eb_reg <= rd_last && rd_b <= elast_reg)
                begin
                    nb_next    = eb_reg;
                    nlast_next = elast_reg;
                    k_next     = i_reg;
                    hits_next  = '0;
                    ret_next   = ira_pkg::R_DONE;
                    state_next = ira_pkg::S_MG_RD;
                end
                else if ((({1'b0, elast_reg} + (A+1)'(1)) == {1'b0, rd_b}) ||
                         (({1'b0, rd_last} + (A+1)'(1)) == {1'b0, eb_reg}))
                begin
                    spb_next   = eb_reg;
                    spy_next   = rd_last;
                    state_next = ira_pkg::S_PO_WR;
                end
                else
                begin
                    fin    = 1'b1;
                    fin_ok = 1'b1;
                end
            end
            ira_pkg::S_PO_WR:
            begin
                mem_we     = 1'b1;
                dst_next   = i_inc;
                gap_next   = CW'(1);
                ret_next   = ira_pkg::R_DONE;
                state_next = ira_pkg::S_SH_RD;
            end
            // merge scan from entry i to the end
            ira_pkg::S_MG_RD:
            begin
                if (k_reg == cnt)
                begin
                    state_next = ira_pkg::S_MG_FIN;
                end
                else
                begin
                    mem_raddr  = {tsel_reg, k_reg[IW-1:0]};
                    state_next = ira_pkg::S_MG_CHK;
                end
            end
            ira_pkg::S_MG_CHK:
            begin
                if (k_reg == i_reg)
                begin
                    firstb_next = rd_b;
                end
                if (c_ovl)
                begin
                    hits_next = hits_reg + CW'(1);
                    endl_next = rd_last;
                end
                k_next     = k_reg + CW'(1);
                state_next = ira_pkg::S_MG_RD;
            end
            ira_pkg::S_MG_FIN:
            begin
                spb_next   = (nb_reg < firstb_reg) ? nb_reg : firstb_reg;
                spy_next   = (endl_reg > nlast_reg) ? endl_reg : nlast_reg;
                state_next = ira_pkg::S_MG_WR;
            end
            ira_pkg::S_MG_WR:
            begin
                mem_we     = 1'b1;
                eb_next    = spb_reg;
                el_next    = sp_len;
                dst_next   = i_inc;
                gap_next   = hits_reg - CW'(1);
                state_next = ira_pkg::S_SH_RD;
            end
            // close a gap: entries above move down by gap
            ira_pkg::S_SH_RD:
            begin
                if (gap_reg == '0 || sh_sum >= {1'b0, cnt})
                begin
                    if (tsel_reg == ira_pkg::TBL_USED)
                    begin
                        used_cnt_next = used_cnt_reg - gap_reg;
                    end
                    else
                    begin
                        pool_cnt_next = pool_cnt_reg - gap_reg;
                    end
                    if (ret_reg == ira_pkg::R_POST)
                    begin
                        state_next = ira_pkg::S_PO_PREP;
                    end
                    else
                    begin
                        fin    = 1'b1;
                        fin_ok = 1'b1;
                    end
                end
                else
                begin
                    mem_raddr  = {tsel_reg, sh_sum[IW-1:0]};
                    state_next = ira_pkg::S_SH_WR;
                end
            end
            ira_pkg::S_SH_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {tsel_reg, dst_reg[IW-1:0]};
                mem_wdata  = mem_rdata;
                dst_next   = dst_reg + CW'(1);
                state_next = ira_pkg::S_SH_RD;
            end
            // ordered insert, moving larger bases up
            ira_pkg::S_INS_RD:
            begin
                if (i_reg == '0)
                begin
                    state_next = ira_pkg::S_INS_WR;
                end
                else
                begin
                    mem_raddr  = {tsel_reg, i_dec[IW-1:0]};
                    state_next = ira_pkg::S_INS_CHK;
                end
            end
            ira_pkg::S_INS_CHK:
            begin
                if (nb_reg < rd_b)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata;
                    i_next     = i_dec;
                    state_next = ira_pkg::S_INS_RD;
                end
                else
                begin
                    state_next = ira_pkg::S_INS_WR;
                end
            end
            ira_pkg::S_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {nb_reg, nl_reg};
                if (tsel_reg == ira_pkg::TBL_USED)
                begin
                    used_cnt_next = used_cnt_reg + CW'(1);
                end
                else
                begin
                    pool_cnt_next = pool_cnt_reg + CW'(1);
                end
                fin    = 1'b1;
                fin_ok = 1'b1;
            end
            // allocate: pool top down, step below blocking used entries
            ira_pkg::S_AL_RD:
            begin
                if (ai_reg == '0)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    ai_next    = ai_dec;
                    mem_raddr  = {ira_pkg::TBL_POOL, ai_dec[IW-1:0]};
                    state_next = ira_pkg::S_AL_DIF;
                end
            end
            ira_pkg::S_AL_DIF:
            begin
                pb_next = rd_b;
                if (rd_l < nl_reg)
                begin
                    state_next = ira_pkg::S_AL_RD;
                end
                else
                begin
                    diff_next  = rd_l - nl_reg;
                    state_next = ira_pkg::S_AL_CAND;
                end
            end
            ira_pkg::S_AL_CAND:
            begin
                cand_next  = (pb_reg + diff_reg) & am;
                state_next = ira_pkg::S_AL_TEST;
            end
            ira_pkg::S_AL_TEST:
            begin
                if (cand_reg == '0 || pb_reg > cand_reg)
                begin
                    state_next = ira_pkg::S_AL_RD;
                end
                else
                begin
                    nlast_next = cand_reg + nl_reg - A'(1);
                    k_next     = '0;
                    state_next = ira_pkg::S_AL_VRD;
                end
            end
            ira_pkg::S_AL_VRD:
            begin
                if (k_reg == used_cnt_reg)
                begin
                    tsel_next  = ira_pkg::TBL_USED;
                    nb_next    = cand_reg;
                    i_next     = '0;
                    state_next = ira_pkg::S_AR_RD;
                end
                else
                begin
                    mem_raddr  = {ira_pkg::TBL_USED, k_reg[IW-1:0]};
                    state_next = ira_pkg::S_AL_VCHK;
                end
            end
            ira_pkg::S_AL_VCHK:
            begin
                if (cand_reg <= rd_last && rd_b <= nlast_reg)
                begin
                    if (rd_b < nl_reg)
                    begin
                        state_next = ira_pkg::S_AL_RD;
                    end
                    else
                    begin
                        cand_next  = (rd_b - nl_reg) & am;
                        state_next = ira_pkg::S_AL_TEST;
                    end
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = ira_pkg::S_AL_VRD;
                end
            end
            // release: find the containing used entry
            ira_pkg::S_RL_RD:
            begin
                if (i_reg == used_cnt_reg)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    state_next = ira_pkg::S_RL_CHK;
                end
            end
            ira_pkg::S_RL_CHK:
            begin
                if (rd_b <= nb_reg && nlast_reg <= rd_last)
                begin
                    rb_next    = rd_b;
                    rl_next    = rd_last;
                    rlen_next  = rd_l;
                    state_next = ira_pkg::S_RL_FIX;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ira_pkg::S_RL_RD;
                end
            end
            ira_pkg::S_RL_FIX:
            begin
                priority if (rb_reg == nb_reg && rl_reg == nlast_reg)
                begin
                    dst_next   = i_reg;
                    gap_next   = CW'(1);
                    ret_next   = ira_pkg::R_DONE;
                    state_next = ira_pkg::S_SH_RD;
                end
                else if (rb_reg == nb_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {nlast_reg + A'(1), rlen_reg - nl_reg};
                    fin       = 1'b1;
                    fin_ok    = 1'b1;
                end
                else if (rl_reg == nlast_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {rb_reg, rlen_reg - nl_reg};
                    fin       = 1'b1;
                    fin_ok    = 1'b1;
                end
                else if (used_cnt_reg >= CW'(MAX_REGIONS))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    // split: keep the front, re-add the tail
                    mem_we     = 1'b1;
                    mem_wdata  = {rb_reg, nb_reg - rb_reg};
                    nb_next    = nlast_reg + A'(1);
                    nl_next    = rl_reg - nlast_reg;
                    nlast_next = rl_reg;
                    i_next     = '0;
                    state_next = ira_pkg::S_AR_RD;
                end
            end
            default:
            begin
                state_next = ira_pkg::S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = ira_pkg::S_IDLE;
        end
    end

    assign res.valid = fin;
    assign res.ok    = fin_ok;
    assign res.addr  = (func_reg == ira_pkg::FUNC_ALLOC && fin_ok) ?
                       ira_pkg::FIELD_W'(cand_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ira_pkg::S_IDLE;
            pool_cnt_reg <= '0;
            used_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pool_cnt_reg <= pool_cnt_next;
            used_cnt_reg <= used_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg    <= ret_next;
        tsel_reg   <= tsel_next;
        func_reg   <= func_next;
        sh_reg     <= sh_next;
        nb_reg     <= nb_next;
        nl_reg     <= nl_next;
        nlast_reg  <= nlast_next;
        cand_reg   <= cand_next;
        endl_reg   <= endl_next;
        firstb_reg <= firstb_next;
        eb_reg     <= eb_next;
        el_reg     <= el_next;
        elast_reg  <= elast_next;
        spb_reg    <= spb_next;
        spy_reg    <= spy_next;
        pb_reg     <= pb_next;
        diff_reg   <= diff_next;
        rb_reg     <= rb_next;
        rl_reg     <= rl_next;
        rlen_reg   <= rlen_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        hits_reg   <= hits_next;
        dst_reg    <= dst_next;
        gap_reg    <= gap_next;
        ai_reg     <= ai_next;
    end

endmodule

// ===== design/iova_range_allocator.sv =====
// iova range allocator top level: request sequencer, region table memory and
// the result register; uses ira_pkg, ira_mem and ira_seq
//
// A transaction is taken when start is high and busy is low. Each request
// gives exactly one result: done is high for one cycle with status (0 ok,
// 1 failure) and addr (allocated base, else 0); the receiver cannot hold it
// off, so it must take every result as it appears. Both region tables live
// in one single-port-read, single-port-write memory and the sequencer touches
// one entry per access. An add scans the pool entries and moves entries for
// an ordered insert or to close a gap after a merge. A release scans the used
// entries until the match, then works as an add when it splits. An allocate
// tries pool entries and checks the used entries for each candidate base, so
// its worst case grows with the product of the two counts. The result is
// registered and shows in the cycle after the sequencer finishes, and busy
// is already low then. Tables come out of reset empty with no clearing pass;
// only entries below each count are ever read.
module iova_range_allocator #(
    parameter int MAX_REGIONS = 64,
    parameter int ADDR_BITS   = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  func,
    input  logic [ira_pkg::FIELD_W-1:0] base,
    input  logic [ira_pkg::FIELD_W-1:0] size,
    input  logic [5:0]                  align_shift,
    output logic                        busy,
    output logic                        done,
    output logic                        status,
    output logic [ira_pkg::FIELD_W-1:0] addr
);

    localparam int IW = $clog2(MAX_REGIONS);

    // memory port between sequencer and table store; entry is {base, len}
    logic                   mem_we;
    logic [IW:0]            mem_waddr;
    logic [2*ADDR_BITS-1:0] mem_wdata;
    logic [IW:0]            mem_raddr;
    logic [2*ADDR_BITS-1:0] mem_rdata;

    ira_pkg::res_t res;

    // result register: one-cycle strobe
    logic                        done_reg;
    logic                        status_reg;
    logic [ira_pkg::FIELD_W-1:0] addr_reg;

    ira_seq #(
        .MAX_REGIONS (MAX_REGIONS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .base        (base),
        .size        (size),
        .align_shift (align_shift),
        .busy        (busy),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // table index msb selects pool or used list
    ira_mem #(
        .AW (IW + 1),
        .DW (2 * ADDR_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    // status and address only load on a finished transaction
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg <= !res.ok;
            addr_reg   <= res.addr;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign addr   = addr_reg;

    // a result only appears once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while sequencer busy");

    // an accepted request always occupies the sequencer next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start the sequencer");

    // a nonzero address is only returned with success
    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && addr != '0) |-> !status)
        else $error("address returned with failure status");

endmodule

// ===== tb/iova_range_allocator_check.sv =====
// checker for the iova range allocator: watches the request and result ports,
// keeps its own copy of the pool and used tables and scores every result
// depends on ira_pkg
module iova_range_allocator_check #(
    parameter int MAX_REGIONS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [1:0]                  func,
    input  logic [ira_pkg::FIELD_W-1:0] base,
    input  logic [ira_pkg::FIELD_W-1:0] size,
    input  logic [5:0]                  align_shift,
    input  logic                        done,
    input  logic                        status,
    input  logic [ira_pkg::FIELD_W-1:0] addr,
    output int                          errors,
    output int                          pending
);

    typedef logic [ira_pkg::FIELD_W-1:0] a_t;
    localparam a_t AMASK = '1;

    typedef struct packed {
        logic st;
        a_t   ad;
    } outcome_t;

    // region tables, indexed by tbl_t
    a_t rgn_base [2][MAX_REGIONS];
    a_t rgn_len  [2][MAX_REGIONS];
    int rgn_cnt  [2];

    outcome_t outcomes_q[$];

    function automatic a_t last_of(a_t b, a_t l);
        return b + l - 1'b1;
    endfunction

    function automatic a_t span(a_t b, a_t last);
        a_t d;
        d = last - b;
        return (d == AMASK) ? AMASK : d + 1'b1;
    endfunction

    function automatic bit touches(a_t b1, a_t e1, a_t b2, a_t e2);
        return b1 <= e2 && b2 <= e1;
    endfunction

    function automatic void drop_entry(ira_pkg::tbl_t t, int r);
        for (int i = r; i + 1 < rgn_cnt[t] && i + 1 < MAX_REGIONS; i++)
        begin
            rgn_base[t][i] = rgn_base[t][i+1];
            rgn_len[t][i]  = rgn_len[t][i+1];
        end
        if (rgn_cnt[t] > 0)
            rgn_cnt[t]--;
    endfunction

    // fold a range into entry first and every later entry it overlaps
    function automatic void fold_from(ira_pkg::tbl_t t, int first, a_t nb, a_t nl);
        a_t nlast, mb, ml, el;
        int hits, endi;
        nlast = last_of(nb, nl);
        hits = 0;
        endi = first;
        for (int k = first; k < rgn_cnt[t]; k++)
        begin
            if (touches(nb, nlast, rgn_base[t][k], last_of(rgn_base[t][k], rgn_len[t][k])))
            begin
                hits++;
                endi = k;
            end
        end
        if (hits == 0)
            return;
        mb = (nb < rgn_base[t][first]) ? nb : rgn_base[t][first];
        el = last_of(rgn_base[t][endi], rgn_len[t][endi]);
        ml = (el > nlast) ? el : nlast;
        rgn_base[t][first] = mb;
        rgn_len[t][first]  = span(mb, ml);
        for (int k = 1; k < hits; k++)
            drop_entry(t, first + 1);
    endfunction

    function automatic bit insert_range(ira_pkg::tbl_t t, a_t nb, a_t nl);
        a_t nlast, rl, l0, b1, l1;
        int n, i, j;
        bit joined;
        nlast = last_of(nb, nl);
        n = rgn_cnt[t];
        joined = 0;
        for (i = 0; i < n; i++)
        begin
            rl = last_of(rgn_base[t][i], rgn_len[t][i]);
            if (nlast != AMASK && nlast + 1'b1 == rgn_base[t][i])
            begin
                rgn_base[t][i] = nb;
                rgn_len[t][i]  = span(nb, rl);
                joined = 1;
                break;
            end
            else if (rl != AMASK && rl + 1'b1 == nb)
            begin
                rgn_len[t][i] = span(rgn_base[t][i], nlast);
                joined = 1;
                break;
            end
            else if (touches(nb, nlast, rgn_base[t][i], rl))
            begin
                fold_from(t, i, nb, nl);
                joined = 1;
                break;
            end
        end
        // the grown entry may now reach its upper neighbor
        if (joined && i + 1 < rgn_cnt[t])
        begin
            l0 = last_of(rgn_base[t][i], rgn_len[t][i]);
            b1 = rgn_base[t][i+1];
            l1 = last_of(b1, rgn_len[t][i+1]);
            if (touches(rgn_base[t][i], l0, b1, l1))
                fold_from(t, i, rgn_base[t][i], rgn_len[t][i]);
            else if ((l0 != AMASK && l0 + 1'b1 == b1) ||
                     (l1 != AMASK && l1 + 1'b1 == rgn_base[t][i]))
            begin
                rgn_len[t][i] = span(rgn_base[t][i], l1);
                drop_entry(t, i + 1);
            end
        end
        if (joined)
            return 1;
        if (n >= MAX_REGIONS)
            return 0;
        j = n;
        while (j > 0 && nb < rgn_base[t][j-1])
        begin
            rgn_base[t][j] = rgn_base[t][j-1];
            rgn_len[t][j]  = rgn_len[t][j-1];
            j--;
        end
        rgn_base[t][j] = nb;
        rgn_len[t][j]  = nl;
        rgn_cnt[t]++;
        return 1;
    endfunction

    // highest aligned free range, stepping below each blocking allocation
    function automatic a_t grant_range(a_t sz, logic [5:0] sh);
        logic [63:0] am64;
        a_t am, pb, pl, cand, clast, ub;
        int j;
        am64 = ~((64'd1 << sh) - 64'd1);
        am = am64[ira_pkg::FIELD_W-1:0];
        if (sz == 0)
            return '0;
        for (int i = rgn_cnt[ira_pkg::TBL_POOL] - 1; i >= 0; i--)
        begin
            pb = rgn_base[ira_pkg::TBL_POOL][i];
            pl = rgn_len[ira_pkg::TBL_POOL][i];
            if (pl < sz)
                continue;
            cand = (pb + (pl - sz)) & am;
            while (cand != 0 && pb <= cand)
            begin
                clast = last_of(cand, sz);
                for (j = 0; j < rgn_cnt[ira_pkg::TBL_USED]; j++)
                    if (touches(cand, clast, rgn_base[ira_pkg::TBL_USED][j],
                                last_of(rgn_base[ira_pkg::TBL_USED][j],
                                        rgn_len[ira_pkg::TBL_USED][j])))
                        break;
                if (j == rgn_cnt[ira_pkg::TBL_USED])
                    return insert_range(ira_pkg::TBL_USED, cand, sz) ? cand : '0;
                ub = rgn_base[ira_pkg::TBL_USED][j];
                if (ub < sz)
                    break;
                cand = (ub - sz) & am;
            end
        end
        return '0;
    endfunction

    function automatic bit free_range(a_t nb, a_t nl);
        a_t nlast, rb, rl;
        int i;
        rb = '0;
        rl = '0;
        if (nl == 0)
            return 0;
        nlast = last_of(nb, nl);
        if (nlast < nb)
            return 0;
        for (i = 0; i < rgn_cnt[ira_pkg::TBL_USED]; i++)
        begin
            rb = rgn_base[ira_pkg::TBL_USED][i];
            rl = last_of(rb, rgn_len[ira_pkg::TBL_USED][i]);
            if (rb <= nb && nlast <= rl)
                break;
        end
        if (i == rgn_cnt[ira_pkg::TBL_USED])
            return 0;
        if (rb == nb && rl == nlast)
        begin
            drop_entry(ira_pkg::TBL_USED, i);
            return 1;
        end
        if (rb == nb)
        begin
            rgn_base[ira_pkg::TBL_USED][i] = nlast + 1'b1;
            rgn_len[ira_pkg::TBL_USED][i]  = rgn_len[ira_pkg::TBL_USED][i] - nl;
            return 1;
        end
        if (rl == nlast)
        begin
            rgn_len[ira_pkg::TBL_USED][i] = rgn_len[ira_pkg::TBL_USED][i] - nl;
            return 1;
        end
        if (rgn_cnt[ira_pkg::TBL_USED] >= MAX_REGIONS)
            return 0;
        rgn_len[ira_pkg::TBL_USED][i] = nb - rb;
        return insert_range(ira_pkg::TBL_USED, nlast + 1'b1, rl - nlast);
    endfunction

    function automatic outcome_t serve_request(logic [1:0] f, a_t b, a_t s,
                                               logic [5:0] sh);
        outcome_t o;
        bit ok;
        ok = 0;
        o.ad = '0;
        case (f)
            ira_pkg::FUNC_ADD:
                if (s != 0 && last_of(b, s) >= b)
                    ok = insert_range(ira_pkg::TBL_POOL, b, s);
            ira_pkg::FUNC_ALLOC:
            begin
                o.ad = grant_range(s, sh);
                ok = (o.ad != 0);
            end
            ira_pkg::FUNC_REL:
                ok = free_range(b, s);
            default:
                ok = 0;
        endcase
        o.st = !ok;
        return o;
    endfunction

    assign pending = outcomes_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            rgn_cnt[ira_pkg::TBL_POOL] = 0;
            rgn_cnt[ira_pkg::TBL_USED] = 0;
            outcomes_q.delete();
            errors = 0;
        end
        else
        begin
            // results are scored before this edge's request, which is always newer
            if (done)
            begin
                if (outcomes_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result: status %0d addr %h", status, addr);
                    errors++;
                end
                else
                begin
                    want = outcomes_q.pop_front();
                    if (want.st !== status || want.ad !== addr)
                    begin
                        if (errors < 10)
                            $display("mismatch: status exp %0d act %0d, addr exp %h act %h",
                                     want.st, status, want.ad, addr);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                outcomes_q.push_back(serve_request(func, base, size, align_shift));
        end
    end

endmodule

// ===== tb/iova_range_allocator_test.sv =====
// testbench top for the iova range allocator: clock, reset, request stimulus,
// watchdog and verdict; depends on ira_pkg, iova_range_allocator and
// iova_range_allocator_check
module iova_range_allocator_test;

    typedef logic [ira_pkg::FIELD_W-1:0] a_t;
    localparam a_t AMASK = '1;
    // most random traffic stays inside this window so ranges collide often
    localparam a_t WIN_LO = 48'h0000_4000_0000;
    localparam int WATCHDOG_LIMIT = 3000000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic [1:0] func;
    a_t         base;
    a_t         size;
    logic [5:0] align_shift;
    logic       busy;
    logic       done;
    logic       status;
    a_t         addr;
    int         errors;
    int         pending;

    // bookkeeping of requests in flight, used to learn granted ranges
    logic [1:0] sent_func_q[$];
    a_t         sent_size_q[$];
    a_t         grant_base_q[$];
    a_t         grant_len_q[$];

    bit quiet;
    int idle_cycles;

    iova_range_allocator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .base        (base),
        .size        (size),
        .align_shift (align_shift),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .addr        (addr)
    );

    iova_range_allocator_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .base        (base),
        .size        (size),
        .align_shift (align_shift),
        .done        (done),
        .status      (status),
        .addr        (addr),
        .errors      (errors),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // issue one transaction and hold it until the block takes it
    task automatic send_request(logic [1:0] f, a_t b, a_t s, logic [5:0] sh);
        start       <= 1'b1;
        func        <= f;
        base        <= b;
        size        <= s;
        align_shift <= sh;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_func_q.push_back(f);
        sent_size_q.push_back(s);
        // random gap after the transaction, except during the quiet stretch
        if (!quiet && $urandom_range(99) < 14)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // release part or all of a range we know was granted
    task automatic send_release();
        int idx;
        a_t gb, gl, off, len;
        idx = $urandom_range(grant_base_q.size() - 1);
        gb = grant_base_q[idx];
        gl = grant_len_q[idx];
        grant_base_q.delete(idx);
        grant_len_q.delete(idx);
        off = '0;
        len = gl;
        case ($urandom_range(3))
            1: if (gl > 1) len = a_t'($urandom_range(1, int'(gl) - 1));   // front
            2: if (gl > 1)
               begin
                   off = a_t'($urandom_range(1, int'(gl) - 1));         // tail
                   len = gl - off;
               end
            3: if (gl > 2)
               begin
                   off = a_t'($urandom_range(1, int'(gl) - 2));         // middle, splits
                   len = a_t'($urandom_range(1, int'(gl - off) - 1));
               end
            default: ;                                                 // whole range
        endcase
        send_request(ira_pkg::FUNC_REL, gb + off, len, 6'($urandom));
    endtask

    // learn allocations from the result stream
    always @(posedge clk)
    begin
        logic [1:0] f;
        a_t s;
        if (rst_n && done && sent_func_q.size() > 0)
        begin
            f = sent_func_q.pop_front();
            s = sent_size_q.pop_front();
            if (f == ira_pkg::FUNC_ALLOC && status == 1'b0 && grant_base_q.size() < 200)
            begin
                grant_base_q.push_back(addr);
                grant_len_q.push_back(s);
            end
        end
    end

    // watchdog: cycles with neither a request taken nor a result seen
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int pick;
        start       <= 1'b0;
        func        <= ira_pkg::FUNC_ADD;
        base        <= '0;
        size        <= '0;
        align_shift <= '0;
        rst_n       <= 1'b0;
        quiet       = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero sizes, unknown func, empty tables
        send_request(ira_pkg::FUNC_ADD, 48'h1000, '0, 6'd0);
        send_request(ira_pkg::FUNC_ALLOC, '0, '0, 6'd0);
        send_request(ira_pkg::FUNC_REL, '0, '0, 6'd0);
        send_request(2'd3, AMASK, AMASK, 6'h3f);
        send_request(ira_pkg::FUNC_ALLOC, '0, 48'h100, 6'd0);
        send_request(ira_pkg::FUNC_REL, 48'h1000, 48'h10, 6'd0);
        // pool built from a base-zero entry, joins from each side, overlap, insert
        send_request(ira_pkg::FUNC_ADD, '0, 48'h4000, 6'd0);
        send_request(ira_pkg::FUNC_ADD, 48'h8000, 48'h1000, 6'd0);
        send_request(ira_pkg::FUNC_ADD, 48'h9000, 48'h1000, 6'd0);
        send_request(ira_pkg::FUNC_ADD, 48'h7000, 48'h1000, 6'd0);
        send_request(ira_pkg::FUNC_ADD, 48'h6800, 48'h1000, 6'd0);
        send_request(ira_pkg::FUNC_ADD, 48'h5000, 48'h800, 6'd0);
        // allocations: aligned, stepping below a blocker, coarse alignment
        send_request(ira_pkg::FUNC_ALLOC, '0, 48'h800, 6'd11);
        send_request(ira_pkg::FUNC_ALLOC, '0, 48'h100, 6'd0);
        send_request(ira_pkg::FUNC_ALLOC, '0, 48'h10, 6'd63);
        send_request(ira_pkg::FUNC_ALLOC, '0, 48'h10, 6'd47);
        // releases: front, tail, split, whole
        send_request(ira_pkg::FUNC_REL, 48'h9700, 48'h80, 6'd0);
        send_request(ira_pkg::FUNC_REL, 48'h9f80, 48'h80, 6'd0);
        send_request(ira_pkg::FUNC_REL, 48'h9900, 48'h100, 6'd0);
        send_request(ira_pkg::FUNC_REL, 48'h9780, 48'h180, 6'd0);
        // range past the top of the address space
        send_request(ira_pkg::FUNC_ADD, AMASK, 48'h2, 6'd0);
        send_request(ira_pkg::FUNC_REL, AMASK, 48'h2, 6'd0);

        // random traffic in a narrow window, with some noise
        for (int n = 0; n < 800; n++)
        begin
            quiet = (n >= 300 && n < 450);
            pick = $urandom_range(99);
            if (pick < 30)
                send_request(ira_pkg::FUNC_ADD, WIN_LO + a_t'($urandom_range(0, 1 << 20)),
                             a_t'($urandom_range(1, 4096)), 6'($urandom));
            else if (pick < 68)
                send_request(ira_pkg::FUNC_ALLOC, a_t'({$urandom, $urandom}),
                             a_t'($urandom_range(1, 2048)),
                             ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(12)));
            else if (pick < 92 && grant_base_q.size() > 0)
                send_release();
            else if (pick < 96)
                send_request(2'($urandom_range(3)), a_t'({$urandom, $urandom}),
                             a_t'({$urandom, $urandom}) >> $urandom_range(47),
                             6'($urandom));
            else
                send_request(2'($urandom_range(2)),
                             WIN_LO + a_t'($urandom_range(0, 1 << 20)),
                             '0, 6'($urandom));
        end
        quiet = 0;

        // extremes: topmost byte, whole address space join, huge requests
        send_request(ira_pkg::FUNC_ADD, AMASK, 48'h1, 6'd0);
        send_request(ira_pkg::FUNC_ADD, 48'h1, AMASK, 6'd0);
        send_request(ira_pkg::FUNC_ADD, '0, AMASK, 6'd0);
        send_request(ira_pkg::FUNC_ALLOC, '0, AMASK, 6'd0);
        send_request(ira_pkg::FUNC_ALLOC, '0, 48'h1, 6'd47);
        send_request(ira_pkg::FUNC_ALLOC, '0, 48'h1, 6'd48);
        send_request(ira_pkg::FUNC_ALLOC, '0, 48'h1000, 6'd0);
        send_request(ira_pkg::FUNC_REL, AMASK, 48'h1, 6'd0);
        send_request(ira_pkg::FUNC_REL, '0, AMASK, 6'd0);

        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ira_pkg.sv
design/ira_mem.sv
design/ira_seq.sv
design/iova_range_allocator.sv
tb/iova_range_allocator_check.sv
tb/iova_range_allocator_test.sv
